@@ design/urrs_pkg.sv @@
package urrs_pkg;

    // Field widths of the event and result words.
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned ID_W     = 16;
    localparam int unsigned PULSE_W  = 8;
    localparam int unsigned CODE_W   = 3;
    localparam int unsigned CFG_IX_W = 2;

    // Packed stream word widths, rounded up to whole bytes.
    localparam int unsigned S_DATA_W = 168;
    localparam int unsigned M_DATA_W = 152;

    // Pulse counter saturates here.
    localparam logic [PULSE_W-1:0] PULSE_MAX = 8'hFF;

    // Register values after reset.
    localparam logic [PULSE_W-1:0] MIN_PULSES_RST    = 8'd40;
    localparam logic [TIME_W-1:0]  COUNT_WINDOW_RST  = 32'd66;
    localparam logic [TIME_W-1:0]  LISTEN_TIMEOUT_RST = 32'd655;
    localparam logic [TIME_W-1:0]  REARM_DELAY_RST   = 32'd1311;

    // Configuration register indexes.
    typedef enum logic [CFG_IX_W-1:0] {
        CFG_MIN_PULSES     = 2'd0,
        CFG_COUNT_WINDOW   = 2'd1,
        CFG_LISTEN_TIMEOUT = 2'd2,
        CFG_REARM_DELAY    = 2'd3
    } cfg_index_t;

    // Event codes carried in the input tuser.
    typedef enum logic [CODE_W-1:0] {
        OP_PULSE    = 3'd0,
        OP_FRAME    = 3'd1,
        OP_PACKET   = 3'd2,
        OP_TICK     = 3'd3,
        OP_ENABLE   = 3'd4,
        OP_TX_REQ   = 3'd5,
        OP_TX_DONE  = 3'd6
    } op_t;

    // Sequencer phase.
    typedef enum logic [CODE_W-1:0] {
        PH_IDLE   = 3'd0,
        PH_COUNT  = 3'd1,
        PH_LISTEN = 3'd2,
        PH_NOISE  = 3'd3,
        PH_TX     = 3'd4
    } phase_t;

    // Result codes carried in the output tuser.
    typedef enum logic [CODE_W-1:0] {
        RK_NONE   = 3'd0,
        RK_OK     = 3'd1,
        RK_FAIL   = 3'd2,
        RK_NOISE  = 3'd3,
        RK_ACCEPT = 3'd4,
        RK_REFUSE = 3'd5,
        RK_TXDONE = 3'd6
    } kind_t;

    // One classified event as it sits in the queue.
    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] now;
        logic              pkt_ok;
        logic [ID_W-1:0]   sender;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] pwall;
        logic [TIME_W-1:0] lwall;
    } event_t;

    // Queue handshake seen from the back end.
    typedef struct packed {
        logic   valid;
        event_t head;
    } queue_out_t;

endpackage

@@ design/urrs_front.sv @@
module urrs_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata, lowest bit up: now, length_ok, packet_sender, packet_preamble,
    // packet_delay, packet_wallclock, local_wallclock, zero fill
    input  logic [urrs_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: opcode
    input  logic [urrs_pkg::CODE_W-1:0]   s_tuser,
    input  logic                          queue_full,
    output logic                          push,
    output urrs_pkg::event_t              push_event
);
    import urrs_pkg::*;

    logic [ID_W-1:0] sender;
    logic [ID_W-1:0] preamble;
    logic            length_ok;

    // Unpack the incoming word.
    assign length_ok = s_tdata[32];
    assign sender    = s_tdata[48:33];
    assign preamble  = s_tdata[64:49];

    // A word is taken whenever the queue has room.
    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    // Classify: decode the event code and check the packet framing up front.
    always_comb
    begin
        push_event.op     = op_t'(s_tuser);
        push_event.now    = s_tdata[31:0];
        push_event.pkt_ok = length_ok && (preamble == ~sender);
        push_event.sender = sender;
        push_event.delay  = s_tdata[96:65];
        push_event.pwall  = s_tdata[128:97];
        push_event.lwall  = s_tdata[160:129];
    end

endmodule

@@ design/urrs_queue.sv @@
module urrs_queue #(
    parameter int unsigned Depth = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  urrs_pkg::event_t       push_event,
    output logic                   full,
    input  logic                   pop,
    output urrs_pkg::queue_out_t   q_out
);
    import urrs_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    event_t            entry_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic              do_pop;

    assign full        = (count_reg == CntW'(Depth));
    assign do_pop      = pop && (count_reg != '0);
    assign q_out.valid = (count_reg != '0);
    assign q_out.head  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_event;
        end
    end

    // The front never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue written while full");

    // Fill count moves by one at most per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone write");

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CntW'(Depth))
        else $error("queue count beyond depth");

endmodule

@@ design/urrs_back.sv @@
module urrs_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [urrs_pkg::CFG_IX_W-1:0]     cfg_index,
    input  logic [urrs_pkg::TIME_W-1:0]       cfg_data,
    input  urrs_pkg::queue_out_t              q_out,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [urrs_pkg::M_DATA_W-1:0]     m_tdata,
    output logic [urrs_pkg::CODE_W-1:0]       m_tuser
);
    import urrs_pkg::*;

    // Configuration registers.
    logic [PULSE_W-1:0] min_pulses_reg;
    logic [TIME_W-1:0]  count_window_reg;
    logic [TIME_W-1:0]  listen_timeout_reg;
    logic [TIME_W-1:0]  rearm_delay_reg;

    // Sequencer state.
    phase_t             phase_reg,         phase_next;
    logic               armed_reg,         armed_next;
    logic               rearm_pending_reg, rearm_pending_next;
    logic [TIME_W-1:0]  rearm_time_reg,    rearm_time_next;
    logic [TIME_W-1:0]  wake_time_reg,     wake_time_next;
    logic [TIME_W-1:0]  frame_time_reg,    frame_time_next;
    logic               frame_seen_reg,    frame_seen_next;
    logic [PULSE_W-1:0] pulse_total_reg,   pulse_total_next;
    logic [TIME_W-1:0]  deadline_reg,      deadline_next;
    logic [TIME_W-1:0]  failures_reg,      failures_next;
    logic [ID_W-1:0]    partner_reg,       partner_next;
    logic [TIME_W-1:0]  partner_wall_reg,  partner_wall_next;
    logic [TIME_W-1:0]  local_stamp_reg,   local_stamp_next;
    logic [TIME_W-1:0]  range_reg,         range_next;
    kind_t              kind_next;

    // Output stage.
    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;
    logic [CODE_W-1:0]    out_user_reg;

    event_t             ev;
    logic [TIME_W-1:0]  gap;
    logic [TIME_W-1:0]  remaining;
    logic               range_good;
    logic               rearm_due;
    logic               window_done;
    logic               deadline_hit;
    logic               is_idle;

    assign ev = q_out.head;

    // An event runs when the output stage is free or being emptied.
    assign pop = q_out.valid && (!out_valid_reg || m_tready);

    // Timing compares, all on wrapping 32-bit differences.
    assign gap          = frame_time_reg - wake_time_reg;
    assign range_good   = frame_seen_reg && (gap < ev.delay);
    assign rearm_due    = rearm_pending_reg && ((ev.now - rearm_time_reg) >= rearm_delay_reg);
    assign window_done  = (ev.now - wake_time_reg) >= count_window_reg;
    assign remaining    = deadline_reg - ev.now;
    assign deadline_hit = (remaining == '0) || (remaining > listen_timeout_reg);
    assign is_idle      = (phase_reg == PH_IDLE);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulses_reg     <= MIN_PULSES_RST;
            count_window_reg   <= COUNT_WINDOW_RST;
            listen_timeout_reg <= LISTEN_TIMEOUT_RST;
            rearm_delay_reg    <= REARM_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIN_PULSES:     min_pulses_reg     <= cfg_data[PULSE_W-1:0];
                CFG_COUNT_WINDOW:   count_window_reg   <= cfg_data;
                CFG_LISTEN_TIMEOUT: listen_timeout_reg <= cfg_data;
                CFG_REARM_DELAY:    rearm_delay_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (pop)
        begin
            unique case (ev.op)
                OP_PULSE:
                begin
                    if (is_idle && armed_reg)
                    begin
                        phase_next = PH_COUNT;
                    end
                end
                OP_PACKET:
                begin
                    if (phase_reg == PH_LISTEN && ev.pkt_ok)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                OP_TICK:
                begin
                    if (phase_reg == PH_COUNT)
                    begin
                        if (window_done)
                        begin
                            phase_next = (pulse_total_reg < min_pulses_reg) ? PH_NOISE
                                                                            : PH_LISTEN;
                        end
                    end
                    else if (phase_reg == PH_LISTEN || phase_reg == PH_NOISE)
                    begin
                        if (deadline_hit)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                OP_TX_REQ:
                begin
                    if (is_idle)
                    begin
                        phase_next = PH_TX;
                    end
                end
                OP_TX_DONE:
                begin
                    if (phase_reg == PH_TX)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result code and the rest of the state.
    always_comb
    begin
        kind_next          = RK_NONE;
        armed_next         = armed_reg;
        rearm_pending_next = rearm_pending_reg;
        rearm_time_next    = rearm_time_reg;
        wake_time_next     = wake_time_reg;
        frame_time_next    = frame_time_reg;
        frame_seen_next    = frame_seen_reg;
        pulse_total_next   = pulse_total_reg;
        deadline_next      = deadline_reg;
        failures_next      = failures_reg;
        partner_next       = partner_reg;
        partner_wall_next  = partner_wall_reg;
        local_stamp_next   = local_stamp_reg;
        range_next         = range_reg;
        if (pop)
        begin
            unique case (ev.op)
                OP_PULSE:
                begin
                    if (is_idle && armed_reg)
                    begin
                        wake_time_next   = ev.now;
                        frame_seen_next  = 1'b0;
                        frame_time_next  = '0;
                        pulse_total_next = PULSE_W'(1);
                    end
                    else if (phase_reg == PH_COUNT && pulse_total_reg != PULSE_MAX)
                    begin
                        pulse_total_next = pulse_total_reg + 1'b1;
                    end
                end
                OP_FRAME:
                begin
                    if ((phase_reg == PH_COUNT || phase_reg == PH_LISTEN) && !frame_seen_reg)
                    begin
                        frame_seen_next = 1'b1;
                        frame_time_next = ev.now;
                    end
                end
                OP_PACKET:
                begin
                    if (phase_reg == PH_LISTEN && ev.pkt_ok)
                    begin
                        if (range_good)
                        begin
                            partner_next      = ev.sender;
                            partner_wall_next = ev.pwall;
                            local_stamp_next  = ev.lwall;
                            range_next        = ev.delay - gap;
                            kind_next         = RK_OK;
                        end
                        else
                        begin
                            failures_next      = failures_reg + 1'b1;
                            rearm_pending_next = 1'b1;
                            rearm_time_next    = ev.now;
                            kind_next          = RK_FAIL;
                        end
                    end
                end
                OP_TICK:
                begin
                    // A pending re-arm is settled before any phase timeout.
                    if (rearm_due)
                    begin
                        rearm_pending_next = 1'b0;
                        if (is_idle)
                        begin
                            armed_next = 1'b1;
                        end
                    end
                    if (phase_reg == PH_COUNT)
                    begin
                        if (window_done)
                        begin
                            armed_next       = 1'b0;
                            pulse_total_next = '0;
                            deadline_next    = ev.now + listen_timeout_reg;
                        end
                    end
                    else if (phase_reg == PH_LISTEN)
                    begin
                        if (deadline_hit)
                        begin
                            failures_next      = failures_reg + 1'b1;
                            rearm_pending_next = 1'b1;
                            rearm_time_next    = ev.now;
                            kind_next          = RK_FAIL;
                        end
                    end
                    else if (phase_reg == PH_NOISE)
                    begin
                        if (deadline_hit)
                        begin
                            rearm_pending_next = 1'b1;
                            rearm_time_next    = ev.now;
                            kind_next          = RK_NOISE;
                        end
                    end
                end
                OP_ENABLE:
                begin
                    if (is_idle)
                    begin
                        rearm_pending_next = 1'b1;
                        rearm_time_next    = ev.now;
                        kind_next          = RK_ACCEPT;
                    end
                    else
                    begin
                        kind_next = RK_REFUSE;
                    end
                end
                OP_TX_REQ:
                begin
                    if (is_idle)
                    begin
                        armed_next = 1'b0;
                        kind_next  = RK_ACCEPT;
                    end
                    else
                    begin
                        kind_next = RK_REFUSE;
                    end
                end
                OP_TX_DONE:
                begin
                    if (phase_reg == PH_TX)
                    begin
                        kind_next = RK_TXDONE;
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            armed_reg         <= 1'b0;
            rearm_pending_reg <= 1'b0;
            rearm_time_reg    <= '0;
            wake_time_reg     <= '0;
            frame_time_reg    <= '0;
            frame_seen_reg    <= 1'b0;
            pulse_total_reg   <= '0;
            deadline_reg      <= '0;
            failures_reg      <= '0;
            partner_reg       <= '0;
            partner_wall_reg  <= '0;
            local_stamp_reg   <= '0;
            range_reg         <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            armed_reg         <= armed_next;
            rearm_pending_reg <= rearm_pending_next;
            rearm_time_reg    <= rearm_time_next;
            wake_time_reg     <= wake_time_next;
            frame_time_reg    <= frame_time_next;
            frame_seen_reg    <= frame_seen_next;
            pulse_total_reg   <= pulse_total_next;
            deadline_reg      <= deadline_next;
            failures_reg      <= failures_next;
            partner_reg       <= partner_next;
            partner_wall_reg  <= partner_wall_next;
            local_stamp_reg   <= local_stamp_next;
            range_reg         <= range_next;
        end
    end

    // Output stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output stage payload: the result code and the state after the event.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_user_reg <= kind_next;
            out_data_reg <= {5'd0, failures_next, range_next, local_stamp_next,
                             partner_wall_next, partner_next, phase_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Pulse detection is never armed once the window has closed or while transmitting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LISTEN || phase_reg == PH_NOISE || phase_reg == PH_TX)
        |-> !armed_reg)
        else $error("armed outside idle or counting");

    // The pulse count only lives inside the counting window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_COUNT) |-> (pulse_total_reg == '0))
        else $error("pulse count left over outside counting");

    // Every reported failure bumps the failure counter by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && kind_next == RK_FAIL) |=> (failures_reg == $past(failures_reg) + 1'b1))
        else $error("failure not counted");

    // State is frozen while no event runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> ($stable(failures_reg) && $stable(phase_reg)))
        else $error("state moved without an event");

endmodule

@@ design/ultrasonic_rf_ranging_sequencer.sv @@
// Channel   Direction  Signals                       Content
// s_*       in         s_tvalid s_tready s_tdata     timestamped event word,
//                      s_tuser                       opcode in tuser
// m_*       out        m_tvalid m_tready m_tdata     one result word per event,
//                      m_tuser                       result kind in tuser
// cfg_*     in         cfg_we cfg_index cfg_data     register writes, no read-back
//
// One event per clock in steady state while m_* does not stall. An accepted event sits
// in the queue, runs in the back end once the output stage is free or being emptied,
// and its result word is then held in the output register on m_* until it is taken.
// Unless m_* stalls, the back end settles one event per cycle in a single
// compare-and-subtract step. Reset (rst_n low, asynchronous) empties the queue and
// output stage and loads the register defaults. A stall on m_tready holds the result;
// the queue keeps taking events until it is full, then s_tready falls.
module ultrasonic_rf_ranging_sequencer #(
    parameter int unsigned QueueDepth = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata, lowest bit up: now, length_ok, packet_sender, packet_preamble,
    // packet_delay, packet_wallclock, local_wallclock, zero fill
    input  logic [urrs_pkg::S_DATA_W-1:0]      s_tdata,
    // s_tuser: opcode
    input  logic [urrs_pkg::CODE_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata, lowest bit up: phase_now, partner, partner_wallclock,
    // local_time_stamp, range_ticks, failure_total, zero fill
    output logic [urrs_pkg::M_DATA_W-1:0]      m_tdata,
    // m_tuser: result_kind
    output logic [urrs_pkg::CODE_W-1:0]        m_tuser,
    input  logic                               cfg_we,
    input  logic [urrs_pkg::CFG_IX_W-1:0]      cfg_index,
    input  logic [urrs_pkg::TIME_W-1:0]        cfg_data
);
    import urrs_pkg::*;

    logic       push;
    event_t     push_event;
    logic       queue_full;
    logic       pop;
    queue_out_t q_out;

    // Event intake and classification.
    urrs_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_event (push_event)
    );

    // Short queue between intake and sequencer.
    urrs_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .full       (queue_full),
        .pop        (pop),
        .q_out      (q_out)
    );

    // Ranging sequencer and output register.
    urrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_out     (q_out),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ verif/ultrasonic_rf_ranging_sequencer_tb.sv @@
module ultrasonic_rf_ranging_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import urrs_pkg::*;

    // Opcode outside the defined set; the sequencer must answer it with no change.
    localparam logic [CODE_W-1:0] OP_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 2000;

    // One expected result word, field by field.
    typedef struct {
        kind_t             kind;
        phase_t            phase;
        logic [ID_W-1:0]   partner;
        logic [TIME_W-1:0] partner_wall;
        logic [TIME_W-1:0] local_stamp;
        logic [TIME_W-1:0] range_len;
        logic [TIME_W-1:0] fail_total;
    } outcome_t;

    // Tracks the ranging state machine and holds the outcomes still owed by the block.
    class ranging_tracker;
        logic [PULSE_W-1:0] min_pulses;
        logic [TIME_W-1:0]  window_len;
        logic [TIME_W-1:0]  listen_len;
        logic [TIME_W-1:0]  rearm_len;

        phase_t             phase;
        bit                 armed;
        bit                 rearm_due;
        logic [TIME_W-1:0]  rearm_from;
        logic [TIME_W-1:0]  wake_at;
        logic [TIME_W-1:0]  frame_at;
        bit                 frame_heard;
        logic [PULSE_W-1:0] pulses;
        logic [TIME_W-1:0]  deadline;
        logic [TIME_W-1:0]  fail_total;
        logic [ID_W-1:0]    partner;
        logic [TIME_W-1:0]  partner_wall;
        logic [TIME_W-1:0]  local_stamp;
        logic [TIME_W-1:0]  range_len;

        outcome_t           due_outcomes[$];
        int unsigned        errors;

        function new();
            min_pulses   = MIN_PULSES_RST;
            window_len   = COUNT_WINDOW_RST;
            listen_len   = LISTEN_TIMEOUT_RST;
            rearm_len    = REARM_DELAY_RST;
            phase        = PH_IDLE;
            armed        = 1'b0;
            rearm_due    = 1'b0;
            rearm_from   = '0;
            wake_at      = '0;
            frame_at     = '0;
            frame_heard  = 1'b0;
            pulses       = '0;
            deadline     = '0;
            fail_total   = '0;
            partner      = '0;
            partner_wall = '0;
            local_stamp  = '0;
            range_len    = '0;
            errors       = 0;
        endfunction

        function void set_register(cfg_index_t ix, logic [TIME_W-1:0] value);
            case (ix)
                CFG_MIN_PULSES:     min_pulses = value[PULSE_W-1:0];
                CFG_COUNT_WINDOW:   window_len = value;
                CFG_LISTEN_TIMEOUT: listen_len = value;
                CFG_REARM_DELAY:    rearm_len  = value;
                default: ;
            endcase
        endfunction

        // Listening and noise wait end once the timer is at or past the deadline.
        function bit deadline_passed(logic [TIME_W-1:0] stamp);
            logic [TIME_W-1:0] remaining;
            remaining = deadline - stamp;
            return (remaining == 0) || (remaining > listen_len);
        endfunction

        function void fail_attempt(logic [TIME_W-1:0] stamp);
            fail_total = fail_total + 1;
            phase      = PH_IDLE;
            rearm_due  = 1'b1;
            rearm_from = stamp;
        endfunction

        // Apply one accepted event word and queue the result it must produce.
        function void note_event(logic [CODE_W-1:0] code, logic [S_DATA_W-1:0] d);
            logic [TIME_W-1:0] stamp;
            logic              len_ok;
            logic [ID_W-1:0]   sender;
            logic [ID_W-1:0]   preamble;
            logic [TIME_W-1:0] delay;
            logic [TIME_W-1:0] gap;
            kind_t             kind;
            outcome_t          o;
            stamp    = d[31:0];
            len_ok   = d[32];
            sender   = d[48:33];
            preamble = d[64:49];
            delay    = d[96:65];
            kind     = RK_NONE;
            case (code)
                OP_PULSE: begin
                    if (phase == PH_IDLE && armed) begin
                        wake_at     = stamp;
                        frame_heard = 1'b0;
                        frame_at    = '0;
                        pulses      = PULSE_W'(1);
                        phase       = PH_COUNT;
                    end else if (phase == PH_COUNT && pulses != PULSE_MAX) begin
                        pulses = pulses + 1'b1;
                    end
                end
                OP_FRAME: begin
                    if ((phase == PH_COUNT || phase == PH_LISTEN) && !frame_heard) begin
                        frame_heard = 1'b1;
                        frame_at    = stamp;
                    end
                end
                OP_PACKET: begin
                    if (phase == PH_LISTEN && len_ok && preamble == ~sender) begin
                        gap = frame_at - wake_at;
                        if (frame_heard && gap < delay) begin
                            partner      = sender;
                            partner_wall = d[128:97];
                            local_stamp  = d[160:129];
                            range_len    = delay - gap;
                            phase        = PH_IDLE;
                            kind         = RK_OK;
                        end else begin
                            fail_attempt(stamp);
                            kind = RK_FAIL;
                        end
                    end
                end
                OP_TICK: begin
                    // The pending re-arm is looked at before the phase timers.
                    if (rearm_due && (stamp - rearm_from) >= rearm_len) begin
                        rearm_due = 1'b0;
                        if (phase == PH_IDLE)
                            armed = 1'b1;
                    end
                    case (phase)
                        PH_COUNT: begin
                            if ((stamp - wake_at) >= window_len) begin
                                armed    = 1'b0;
                                phase    = (pulses < min_pulses) ? PH_NOISE : PH_LISTEN;
                                pulses   = '0;
                                deadline = stamp + listen_len;
                            end
                        end
                        PH_LISTEN: begin
                            if (deadline_passed(stamp)) begin
                                fail_attempt(stamp);
                                kind = RK_FAIL;
                            end
                        end
                        PH_NOISE: begin
                            if (deadline_passed(stamp)) begin
                                phase      = PH_IDLE;
                                rearm_due  = 1'b1;
                                rearm_from = stamp;
                                kind       = RK_NOISE;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_ENABLE: begin
                    if (phase == PH_IDLE) begin
                        rearm_due  = 1'b1;
                        rearm_from = stamp;
                        kind       = RK_ACCEPT;
                    end else begin
                        kind = RK_REFUSE;
                    end
                end
                OP_TX_REQ: begin
                    if (phase == PH_IDLE) begin
                        phase = PH_TX;
                        armed = 1'b0;
                        kind  = RK_ACCEPT;
                    end else begin
                        kind = RK_REFUSE;
                    end
                end
                OP_TX_DONE: begin
                    if (phase == PH_TX) begin
                        phase = PH_IDLE;
                        kind  = RK_TXDONE;
                    end
                end
                default: ;
            endcase
            o.kind         = kind;
            o.phase        = phase;
            o.partner      = partner;
            o.partner_wall = partner_wall;
            o.local_stamp  = local_stamp;
            o.range_len    = range_len;
            o.fail_total   = fail_total;
            due_outcomes.push_back(o);
        endfunction

        function void compare_field(string name, logic [TIME_W-1:0] want,
                                    logic [TIME_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result word against the oldest outcome owed.
        function void check_outcome(logic [CODE_W-1:0] kind_bits, logic [M_DATA_W-1:0] d);
            outcome_t o;
            if (due_outcomes.size() == 0) begin
                $error("result word with no event outstanding: kind 0x%0h", kind_bits);
                errors++;
            end else begin
                o = due_outcomes.pop_front();
                compare_field("result_kind", TIME_W'(o.kind), TIME_W'(kind_bits));
                compare_field("phase_now", TIME_W'(o.phase), TIME_W'(d[2:0]));
                compare_field("partner", TIME_W'(o.partner), TIME_W'(d[18:3]));
                compare_field("partner_wallclock", o.partner_wall, d[50:19]);
                compare_field("local_time_stamp", o.local_stamp, d[82:51]);
                compare_field("range_ticks", o.range_len, d[114:83]);
                compare_field("failure_total", o.fail_total, d[146:115]);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [CODE_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [CODE_W-1:0]     m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IX_W-1:0]   cfg_index = '0;
    logic [TIME_W-1:0]     cfg_data = '0;

    ranging_tracker        tracker = new();
    int                    src_idle_pct = 31;
    int                    sink_idle_pct = 86;
    int                    words_sent = 0;
    int                    quiet_cycles = 0;
    logic [TIME_W-1:0]     tnow = '0;

    ultrasonic_rf_ranging_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // The receiver stalls at random with the current percentage.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Both sides are watched at every edge: events feed the tracker, results are checked.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                tracker.note_event(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                tracker.check_outcome(m_tuser, m_tdata);
        end
    end

    // Count edges with no word moving on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Small random slack past a boundary, none where it would wrap past the span.
    function automatic logic [TIME_W-1:0] slack(logic [TIME_W-1:0] span);
        return (span > 32'hFFFF_0000) ? 32'd0 : 32'($urandom_range(0, 3));
    endfunction

    // Present one event word, with random sender gaps, and return at its acceptance edge.
    task automatic drive_word(logic [CODE_W-1:0] code, logic [TIME_W-1:0] stamp,
                              logic len_ok, logic [ID_W-1:0] sender,
                              logic [ID_W-1:0] preamble, logic [TIME_W-1:0] delay);
        logic [TIME_W-1:0] pwall;
        logic [TIME_W-1:0] lwall;
        pwall = $urandom;
        lwall = $urandom;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= {7'd0, lwall, pwall, delay, preamble, sender, len_ok, stamp};
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
    endtask

    // Events other than packets: the packet fields carry random filler.
    task automatic send_event(logic [CODE_W-1:0] code, logic [TIME_W-1:0] stamp);
        drive_word(code, stamp, 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                   $urandom);
    endtask

    // Stop sending and wait until every result owed has come back; the first edge
    // lets the last accepted word reach the tracker.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.due_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Write all four registers on consecutive edges while the block is idle.
    task automatic load_settings(logic [PULSE_W-1:0] mp, logic [TIME_W-1:0] win,
                                 logic [TIME_W-1:0] tmo, logic [TIME_W-1:0] rea);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIN_PULSES;
        cfg_data  <= {24'd0, mp};
        @(posedge clk);
        cfg_index <= CFG_COUNT_WINDOW;
        cfg_data  <= win;
        @(posedge clk);
        cfg_index <= CFG_LISTEN_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge clk);
        cfg_index <= CFG_REARM_DELAY;
        cfg_data  <= rea;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_register(CFG_MIN_PULSES, {24'd0, mp});
        tracker.set_register(CFG_COUNT_WINDOW, win);
        tracker.set_register(CFG_LISTEN_TIMEOUT, tmo);
        tracker.set_register(CFG_REARM_DELAY, rea);
    endtask

    // One well-formed ranging attempt: enable, arm, pulse burst, window close, then
    // a matching packet, a late one, or silence until the deadline; or a transmit instead.
    task automatic run_attempt();
        logic [TIME_W-1:0] t_en;
        logic [TIME_W-1:0] t_wake;
        logic [TIME_W-1:0] t_close;
        logic [TIME_W-1:0] gap_seen;
        logic [ID_W-1:0]   id;
        int                n;
        int                frame_pos;
        int                i;
        bit                framed;
        bit                quiet;
        tnow = tnow + $urandom_range(1, 40);
        t_en = tnow;
        send_event(OP_ENABLE, t_en);
        if (tracker.rearm_len != 0 && $urandom_range(0, 3) == 0)
            send_event(OP_TICK, t_en + $urandom_range(0, tracker.rearm_len - 1));

        // A transmit while the re-arm is pending makes the re-arm get dropped.
        if ($urandom_range(0, 9) == 0) begin
            send_event(OP_TX_REQ, t_en);
            send_event(OP_PULSE, t_en);
            send_event(OP_ENABLE, t_en);
            send_event(OP_TICK, t_en + tracker.rearm_len + slack(tracker.rearm_len));
            send_event(OP_TX_DONE, t_en);
            return;
        end
        send_event(OP_TICK, t_en + tracker.rearm_len + slack(tracker.rearm_len));

        // Pulse burst, mostly at or above the threshold; the frame start may land
        // after any pulse or only once listening.
        if (tracker.min_pulses > 1 && $urandom_range(0, 3) == 0)
            n = $urandom_range(1, tracker.min_pulses - 1);
        else
            n = tracker.min_pulses + $urandom_range(0, 3);
        if (n == 0)
            n = 1;
        framed    = ($urandom_range(0, 4) != 0);
        frame_pos = $urandom_range(0, n);
        gap_seen  = $urandom_range(0, 200);
        t_wake    = tnow + $urandom_range(0, 50);
        for (i = 0; i < n; i++) begin
            send_event(OP_PULSE, t_wake + i);
            if (framed && i == frame_pos) begin
                send_event(OP_FRAME, t_wake + gap_seen);
                if ($urandom_range(0, 3) == 0)
                    send_event(OP_FRAME, t_wake + gap_seen + 1);
            end
            if ($urandom_range(0, 15) == 0)
                send_event(OP_TICK, t_wake + $urandom_range(0, tracker.window_len - 1));
        end
        t_close = t_wake + tracker.window_len + slack(tracker.window_len);
        send_event(OP_TICK, t_close);
        if (framed && frame_pos == n)
            send_event(OP_FRAME, t_wake + gap_seen);

        quiet = 1'b1;
        if (n >= tracker.min_pulses) begin
            // Stray packets are ignored while listening.
            id = ID_W'($urandom);
            if ($urandom_range(0, 1))
                drive_word(OP_PACKET, t_close, 1'b0, id, ~id, $urandom);
            if ($urandom_range(0, 1))
                drive_word(OP_PACKET, t_close, 1'b1, id,
                           ~id ^ (16'd1 << $urandom_range(0, 15)), $urandom);
            if ($urandom_range(0, 3) == 0)
                send_event(OP_ENABLE, t_close);
            case ($urandom_range(0, 3))
                0, 1: begin
                    drive_word(OP_PACKET, t_close, 1'b1, id, ~id,
                               gap_seen + $urandom_range(1, 5000));
                    quiet = 1'b0;
                end
                2: begin
                    drive_word(OP_PACKET, t_close, 1'b1, id, ~id,
                               gap_seen - $urandom_range(0, gap_seen));
                    quiet = 1'b0;
                end
                default: ;
            endcase
        end
        // Silence: an early tick, then one at or just past the deadline.
        if (quiet) begin
            if ($urandom_range(0, 1))
                send_event(OP_TICK, t_close + $urandom_range(0, tracker.listen_len - 1));
            send_event(OP_TICK, t_close + tracker.listen_len + slack(tracker.listen_len));
        end
        tnow = t_close;
    endtask

    // A burst of fully random words, including the unused opcode, then a nudge back to idle.
    task automatic run_noise();
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] junk;
        int              count;
        count = $urandom_range(3, 12);
        repeat (count) begin
            id   = ID_W'($urandom);
            junk = ID_W'($urandom);
            drive_word(CODE_W'($urandom_range(0, 7)), $urandom, 1'($urandom_range(0, 1)), id,
                       $urandom_range(0, 1) ? ~id : junk, $urandom);
        end
        send_event(OP_TX_DONE, tnow);
        repeat (2) begin
            tnow = tnow + 32'h8000_0000;
            send_event(OP_TICK, tnow);
        end
    endtask

    initial
    begin
        logic [TIME_W-1:0] t;
        int                ph;
        int                phase_end;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nothing is armed after reset, so pulse, frame and packet are ignored.
        send_event(OP_PULSE, 32'h0000_0000);
        send_event(OP_FRAME, 32'hFFFF_FFFF);
        drive_word(OP_PACKET, 32'h0000_0000, 1'b1, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
        drive_word(OP_UNUSED, 32'hFFFF_FFFF, 1'b0, 16'h0000, 16'hFFFF, 32'h0000_0000);
        send_event(OP_TX_DONE, 32'd1);

        // Transmit round trip, with requests refused while it runs.
        send_event(OP_TX_REQ, 32'd2);
        send_event(OP_ENABLE, 32'd3);
        send_event(OP_TX_REQ, 32'd4);
        send_event(OP_TX_DONE, 32'd5);

        // Re-arm across the timer wrap, one tick short and then on time.
        send_event(OP_ENABLE, 32'hFFFF_FF00);
        send_event(OP_TICK, 32'hFFFF_FF00 + REARM_DELAY_RST - 1);
        send_event(OP_TICK, 32'hFFFF_FF00 + REARM_DELAY_RST);

        // A single pulse: only the first frame start counts, enable is refused, and the
        // window closes into the noise wait, which ends exactly at its deadline.
        t = 32'h0000_1000;
        send_event(OP_PULSE, t);
        send_event(OP_FRAME, t + 5);
        send_event(OP_FRAME, t + 9);
        send_event(OP_ENABLE, t + 10);
        send_event(OP_TICK, t + COUNT_WINDOW_RST - 1);
        send_event(OP_TICK, t + COUNT_WINDOW_RST);
        send_event(OP_TICK, t + COUNT_WINDOW_RST + LISTEN_TIMEOUT_RST - 1);
        send_event(OP_TICK, t + COUNT_WINDOW_RST + LISTEN_TIMEOUT_RST);
        settle();

        // With no pulse threshold one pulse leads to listening; bad packets are ignored
        // and a good one without a frame start is a failure.
        load_settings(8'd0, COUNT_WINDOW_RST, LISTEN_TIMEOUT_RST, 32'd0);
        t = 32'h0000_2000;
        send_event(OP_TICK, t);
        send_event(OP_PULSE, t + 1);
        send_event(OP_TICK, t + 1 + COUNT_WINDOW_RST);
        drive_word(OP_PACKET, t + 80, 1'b0, 16'h1234, ~16'h1234, 32'd500);
        drive_word(OP_PACKET, t + 81, 1'b1, 16'h1234, 16'h1234, 32'd500);
        drive_word(OP_PACKET, t + 82, 1'b1, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
        settle();

        // Random attempts under several settings, extremes included; the idle
        // pattern moves from sender-light to receiver-light to none.
        tnow = $urandom;
        for (ph = 0; ph < 6; ph++) begin
            src_idle_pct  = (ph < 2) ? 31 : (ph < 4) ? 86 : 0;
            sink_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 31 : 0;
            case (ph)
                0: load_settings(PULSE_W'($urandom_range(1, 6)), $urandom_range(2, 100),
                                 $urandom_range(2, 300), $urandom_range(0, 500));
                1: load_settings(8'd0, 32'd1, 32'd1, 32'd0);
                2: load_settings(PULSE_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: load_settings(MIN_PULSES_RST, COUNT_WINDOW_RST, LISTEN_TIMEOUT_RST,
                                 REARM_DELAY_RST);
                4: load_settings(PULSE_W'($urandom_range(1, 8)), $urandom_range(1, 500),
                                 $urandom_range(1, 2000), $urandom_range(0, 3000));
                default: load_settings(PULSE_W'($urandom_range(0, 3)), $urandom_range(1, 10),
                                       $urandom_range(1, 10), $urandom_range(0, 10));
            endcase
            phase_end = words_sent + ((ph == 2) ? 400 : 220);
            while (words_sent < phase_end) begin
                if ($urandom_range(0, 9) == 0)
                    run_noise();
                else
                    run_attempt();
            end
            settle();
        end

        repeat (8) @(posedge clk);
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
design/urrs_pkg.sv
design/urrs_front.sv
design/urrs_queue.sv
design/urrs_back.sv
design/ultrasonic_rf_ranging_sequencer.sv
verif/ultrasonic_rf_ranging_sequencer_tb.sv
